// File: rtl/tdt_pkg.sv
package tdt_pkg;

    localparam int CHAR_CODES  = 128;
    localparam int NUM_STATES  = 11;
    localparam int TABLE_DEPTH = CHAR_CODES * NUM_STATES;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int CHAR_W  = 7;
    localparam int COL_W   = 4;
    localparam int STATE_W = 7;
    localparam int TYPE_W  = 3;

    // Most results one input can cause, and the result queue around them
    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [STATE_W-1:0] ST_START    = 7'd0;
    localparam logic [STATE_W-1:0] ST_WORD     = 7'd1;
    localparam logic [STATE_W-1:0] ST_INT      = 7'd2;
    localparam logic [STATE_W-1:0] ST_REAL     = 7'd4;
    localparam logic [STATE_W-1:0] ST_REAL_EXP = 7'd9;
    localparam logic [STATE_W-1:0] ST_SPECIAL  = 7'd10;
    localparam logic [STATE_W-1:0] ST_DELIM    = 7'd55;
    localparam logic [STATE_W-1:0] ST_ERROR    = 7'd99;

    localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;

    localparam logic [TYPE_W-1:0] TT_WORD    = 3'd0;
    localparam logic [TYPE_W-1:0] TT_INT     = 3'd1;
    localparam logic [TYPE_W-1:0] TT_REAL    = 3'd2;
    localparam logic [TYPE_W-1:0] TT_SPECIAL = 3'd3;
    localparam logic [TYPE_W-1:0] TT_NONE    = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_CHAR = 2'd1,
        OP_EOF  = 2'd2,
        OP_RSVD = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [CHAR_W-1:0]  ch;
        logic [TYPE_W-1:0]  ttype;
        logic               last;
    } result_t;

    // Up to three results written into the queue in one cycle
    typedef struct packed {
        logic [1:0]                 cnt;
        result_t [MAX_RES-1:0]      res;
    } push_t;

    typedef struct packed {
        logic                we;
        logic                re;
        logic [ADDR_W-1:0]   addr;
        logic [STATE_W-1:0]  wdata;
    } ram_req_t;

    function automatic logic [TYPE_W-1:0] type_of(input logic [STATE_W-1:0] s);
        logic [TYPE_W-1:0] t;
        case (s)
            ST_WORD:                       t = TT_WORD;
            ST_INT:                        t = TT_INT;
            ST_REAL, ST_REAL_EXP:          t = TT_REAL;
            ST_START, ST_SPECIAL, ST_DELIM: t = TT_SPECIAL;
            default:                       t = TT_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [ADDR_W-1:0] table_addr(input logic [CHAR_W-1:0]  c,
                                                     input logic [STATE_W-1:0] s);
        return ADDR_W'(c) * ADDR_W'(NUM_STATES) + ADDR_W'(s);
    endfunction

    function automatic result_t mk_res(input kind_t kind, input logic [CHAR_W-1:0] ch,
                                       input logic [TYPE_W-1:0] ttype);
        result_t r;
        r.kind  = kind;
        r.ch    = ch;
        r.ttype = ttype;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/tdt_table_ram.sv
module tdt_table_ram
    import tdt_pkg::*;
(
    input  logic                clk,
    input  ram_req_t            req,
    output logic [STATE_W-1:0]  q
);

    logic [STATE_W-1:0] mem [TABLE_DEPTH];
    logic [STATE_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            q_reg <= mem[req.addr];
        end
    end

    assign q = q_reg;

endmodule

// File: rtl/tdt_result_fifo.sv
module tdt_result_fifo
    import tdt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  push_t    push,
    output logic     room,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_res
);

    result_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic [FIFO_CNT_W-1:0]  count_next;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Room for the worst case of one input item
    assign room      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RES));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (2'(k) < push.cnt)
            begin
                entry_reg[wr_ptr_reg + FIFO_PTR_W'(k)] <= push.res[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/tdt_lexer.sv
module tdt_lexer
    import tdt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  op_t                 op,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [COL_W-1:0]    entry_state,
    input  logic [STATE_W-1:0]  entry_next,
    input  logic                room,
    output ram_req_t            ram_req,
    input  logic [STATE_W-1:0]  ram_q,
    output push_t               push
);

    logic [STATE_W-1:0]  state_reg,  state_next;
    logic                v1_reg,     v1_next;
    logic                rep_reg,    rep_next;
    op_t                 op1_reg,    op1_next;
    logic [CHAR_W-1:0]   c1_reg,     c1_next;
    logic [STATE_W-1:0]  prev1_reg,  prev1_next;
    logic                inr1_reg,   inr1_next;
    logic [TYPE_W-1:0]   pend_reg,   pend_next;
    logic                accept;

    assign in_ready = !v1_reg && room;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [STATE_W-1:0] n;
        logic [STATE_W-1:0] adv_prev;
        logic               adv_en;
        logic [1:0]         cnt;
        result_t            slot [MAX_RES];

        state_next = state_reg;
        v1_next    = v1_reg;
        rep_next   = rep_reg;
        op1_next   = op1_reg;
        c1_next    = c1_reg;
        prev1_next = prev1_reg;
        inr1_next  = inr1_reg;
        pend_next  = pend_reg;
        ram_req    = '0;
        cnt        = '0;
        adv_en     = 1'b0;
        adv_prev   = prev1_reg;
        for (int k = 0; k < MAX_RES; k++)
        begin
            slot[k] = mk_res(KIND_NONE, '0, TT_NONE);
        end

        // An entry outside the table reads as an error
        n = inr1_reg ? ram_q : ST_ERROR;

        // Accept side: loads write at once, characters start their lookup, end of input waits for evaluation
        if (accept)
        begin
            case (op)
                OP_LOAD:
                begin
                    if (32'(char_code) < CHAR_CODES && 32'(entry_state) < NUM_STATES)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.addr  = table_addr(char_code, STATE_W'(entry_state));
                        ram_req.wdata = entry_next;
                    end
                end
                OP_CHAR:
                begin
                    ram_req.re = 1'b1;
                    ram_req.addr = table_addr(char_code, state_reg);
                    v1_next    = 1'b1;
                    op1_next   = OP_CHAR;
                    c1_next    = char_code;
                    prev1_next = state_reg;
                    inr1_next  = (32'(char_code) < CHAR_CODES) && (32'(state_reg) < NUM_STATES);
                end
                OP_EOF:
                begin
                    v1_next  = 1'b1;
                    op1_next = OP_EOF;
                end
                default:
                begin
                end
            endcase
        end

        // Evaluate side
        if (v1_reg)
        begin
            if (op1_reg == OP_EOF)
            begin
                if (state_reg == ST_WORD || state_reg == ST_INT || state_reg == ST_REAL ||
                    state_reg == ST_REAL_EXP || state_reg == ST_SPECIAL ||
                    state_reg == ST_DELIM)
                begin
                    slot[0] = mk_res(KIND_END, '0, type_of(state_reg));
                end
                else
                begin
                    slot[0] = mk_res(KIND_NONE, '0, TT_NONE);
                end
                cnt        = 2'd1;
                state_next = ST_START;
                v1_next    = 1'b0;
            end
            else if (!rep_reg)
            begin
                if (n == ST_DELIM)
                begin
                    state_next = ST_START;
                    if (c1_reg == CH_SPACE)
                    begin
                        slot[0] = mk_res(KIND_END, '0, type_of(prev1_reg));
                        cnt     = 2'd1;
                        v1_next = 1'b0;
                    end
                    else
                    begin
                        // Hold the token end and run the character again from start
                        rep_next     = 1'b1;
                        pend_next    = type_of(prev1_reg);
                        inr1_next    = 1'b1;
                        ram_req.re   = 1'b1;
                        ram_req.addr = table_addr(c1_reg, ST_START);
                    end
                end
                else
                begin
                    adv_en  = 1'b1;
                    v1_next = 1'b0;
                end
            end
            else
            begin
                slot[0]  = mk_res(KIND_END, '0, pend_reg);
                cnt      = 2'd1;
                adv_prev = ST_START;
                if (n == ST_DELIM)
                begin
                    slot[1] = mk_res(KIND_ERROR, c1_reg, TT_NONE);
                    cnt     = 2'd2;
                end
                else
                begin
                    adv_en = 1'b1;
                end
                rep_next = 1'b0;
                v1_next  = 1'b0;
            end

            if (adv_en)
            begin
                if (n == ST_ERROR)
                begin
                    slot[cnt]  = mk_res(KIND_ERROR, c1_reg, TT_NONE);
                    cnt        = cnt + 2'd1;
                    state_next = ST_START;
                end
                else
                begin
                    if (n != ST_START)
                    begin
                        slot[cnt] = mk_res(KIND_CHAR, c1_reg, TT_NONE);
                        cnt       = cnt + 2'd1;
                    end
                    if (n == ST_SPECIAL)
                    begin
                        slot[cnt]  = mk_res(KIND_END, '0, type_of(adv_prev));
                        cnt        = cnt + 2'd1;
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = n;
                    end
                end
            end

            // Flag the final result of this item
            if (cnt != 2'd0)
            begin
                slot[cnt - 2'd1].last = 1'b1;
            end
        end

        push.cnt = cnt;
        for (int k = 0; k < MAX_RES; k++)
        begin
            push.res[k] = slot[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            v1_reg    <= 1'b0;
            rep_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= v1_next;
            rep_reg   <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg   <= op1_next;
        c1_reg    <= c1_next;
        prev1_reg <= prev1_next;
        inr1_reg  <= inr1_next;
        pend_reg  <= pend_next;
    end

endmodule

// File: rtl/table_driven_dfa_tokenizer_top.sv
// Table-driven DFA tokenizer.
// Input stream (s_axis): tuser carries the operation (load table entry,
// character, end of input); tdata carries the character or table row, the
// table column and the next-state value to store. Output stream (m_axis):
// tuser carries the result kind, tdata the character and the token type,
// tlast marks the final result caused by one input transaction.
// Load the whole transition table before sending characters; a table
// entry lives in a single-port synchronous RAM of 128 x 11 words.
// A load transaction writes the RAM when it is accepted. A character
// goes through a RAM read and then an evaluation; a character that ends
// a token on a delimiter and must be run again takes a second RAM read
// and evaluation. End of input is only evaluated. Results are written
// to the queue when evaluated and appear on m_axis from its registers.
// Results go through an 8-entry queue, so input is taken while earlier
// results still wait; s_axis_tready drops while an item is being evaluated
// or while the queue lacks room for three more results.
// Reset clears the lexer state to the start state and empties the queue;
// the table contents are undefined until written.
// When the receiver stalls, the queue fills and then holds off the input.
module table_driven_dfa_tokenizer_top
    import tdt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // char_code[6:0], entry_state[10:7], entry_next[17:11]
    input  logic [1:0]   s_axis_tuser,   // op[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,   // out_char[6:0], token_type[9:7]
    output logic [1:0]   m_axis_tuser,   // kind[1:0]
    output logic         m_axis_tlast
);

    ram_req_t            ram_req;
    logic [STATE_W-1:0]  ram_q;
    push_t               push;
    logic                room;
    result_t             head;

    tdt_table_ram u_table
    (
        .clk  (clk),
        .req  (ram_req),
        .q    (ram_q)
    );

    tdt_lexer u_lexer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .op          (op_t'(s_axis_tuser)),
        .char_code   (s_axis_tdata[6:0]),
        .entry_state (s_axis_tdata[10:7]),
        .entry_next  (s_axis_tdata[17:11]),
        .room        (room),
        .ram_req     (ram_req),
        .ram_q       (ram_q),
        .push        (push)
    );

    tdt_result_fifo u_results
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (head)
    );

    // Drive the output transaction from the queue head
    assign m_axis_tdata = {6'b0, head.ttype, head.ch};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule
